// ----- rtl/dcbr_pkg.sv -----
// ============================================================================
// dcbr_pkg - shared types and constants of the depthwise conv1d block
// Sizes, opcodes and the job record passed from the front end to the
// arithmetic back end.
// ============================================================================
package dcbr_pkg;

    localparam int CHANNELS  = 16;
    localparam int TAPS      = 5;
    localparam int CLAMP_MAX = 127;

    // Field widths of the item and result channels.
    localparam int OPC_W  = 2;
    localparam int CH_W   = 4;
    localparam int TI_W   = 3;
    localparam int SMP_W  = 8;
    localparam int BIAS_W = 32;
    localparam int POS_W  = 16;
    localparam int VAL_W  = 7;

    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_N     = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int HIST_IDX_W = (HIST_N > 1) ? $clog2(HIST_N) : 1;
    localparam int FILL_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int TAP_IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam int PROD_W = 2 * SMP_W;
    localparam int PSUM_W = PROD_W + $clog2(TAPS) + 1;
    localparam int ACC_W  = ((PSUM_W > BIAS_W) ? PSUM_W : BIAS_W) + 1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_W-1:0] OUTPUT_COUNT_RST = POS_W'(512);

    typedef enum logic [OPC_W-1:0] {
        OP_SAMPLE    = 2'd0,
        OP_LOAD_TAP  = 2'd1,
        OP_LOAD_BIAS = 2'd2,
        OP_RESTART   = 2'd3
    } t_opcode;

    typedef logic signed [SMP_W-1:0] t_sample;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [POS_W-1:0] position;
        logic             is_last;
    } t_meta;

    typedef struct packed {
        t_sample [TAPS-1:0]       window;
        t_sample [TAPS-1:0]       taps;
        logic signed [BIAS_W-1:0] bias;
        t_meta                    meta;
    } t_job;

endpackage

// ----- rtl/dcbr_if.sv -----
// ============================================================================
// dcbr_if - channel interfaces of the depthwise conv1d block
// Item, result and configuration channels, each with valid and ready.
// ============================================================================
interface dcbr_in_if;
    import dcbr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic [CH_W-1:0]          channel;
    logic [TI_W-1:0]          tap_index;
    logic signed [SMP_W-1:0]  value;
    logic signed [BIAS_W-1:0] bias_value;

    modport source (output valid, opcode, channel, tap_index, value, bias_value,
                    input ready);
    modport sink (input valid, opcode, channel, tap_index, value, bias_value,
                  output ready);
endinterface

interface dcbr_out_if;
    import dcbr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_channel;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] output_value;
    logic             is_last;

    modport source (output valid, out_channel, position, output_value, is_last,
                    input ready);
    modport sink (input valid, out_channel, position, output_value, is_last,
                  output ready);
endinterface

interface dcbr_cfg_if;
    import dcbr_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/dcbr_front.sv -----
// ============================================================================
// dcbr_front - item decode and per-channel sequence state
// Accepts items, updates taps, biases, history, fill levels and positions,
// and hands each window that completes a result to the job queue.
// ============================================================================
module dcbr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dcbr_in_if.sink       i_in,
    dcbr_cfg_if.sink      i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output dcbr_pkg::t_job o_job
);
    import dcbr_pkg::*;

    logic [POS_W-1:0]         r_output_count;
    logic [FILL_W-1:0]        r_fill [CHANNELS];
    logic [POS_W-1:0]         r_pos  [CHANNELS];
    t_sample [HIST_N-1:0]     r_hist [CHANNELS];
    t_sample [TAPS-1:0]       r_taps [CHANNELS];
    logic signed [BIAS_W-1:0] r_bias [CHANNELS];

    logic                 accept;
    logic                 ch_ok;
    logic [CH_IDX_W-1:0]  ch;
    t_opcode              opc;
    logic [FILL_W-1:0]    fill_cur;
    logic [POS_W-1:0]     pos_cur;
    t_sample [HIST_N-1:0] hist_row;
    t_sample [HIST_N-1:0] hist_shifted;
    logic                 filling;
    logic                 seq_open;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;

    assign opc      = t_opcode'(i_in.opcode);
    assign ch_ok    = (32'(i_in.channel) < CHANNELS);
    assign ch       = CH_IDX_W'(i_in.channel);
    assign fill_cur = r_fill[ch];
    assign pos_cur  = r_pos[ch];
    assign hist_row = r_hist[ch];
    assign filling  = (32'(fill_cur) < TAPS - 1);
    assign seq_open = (pos_cur < r_output_count);

    always_comb begin
        for (int k = 0; k < HIST_N; k++) begin
            if (k < HIST_N - 1) begin
                hist_shifted[k] = hist_row[k+1];
            end else begin
                hist_shifted[k] = i_in.value;
            end
        end
    end

    // The window is taken from the state as it stands before this item, with
    // the newest sample in the last tap position.
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            if (k < TAPS - 1) begin
                o_job.window[k] = hist_row[k];
            end else begin
                o_job.window[k] = i_in.value;
            end
        end
        o_job.taps          = r_taps[ch];
        o_job.bias          = r_bias[ch];
        o_job.meta.channel  = i_in.channel;
        o_job.meta.position = pos_cur;
        o_job.meta.is_last  = ((17'(pos_cur) + 17'd1) == 17'(r_output_count));
    end

    assign o_push = accept && ch_ok && (opc == OP_SAMPLE) && !filling && seq_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_count <= OUTPUT_COUNT_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                r_fill[c] <= '0;
                r_pos[c]  <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_output_count <= i_cfg.data;
            end
            if (accept) begin
                if (opc == OP_RESTART) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_fill[c] <= '0;
                        r_pos[c]  <= '0;
                    end
                end else if (ch_ok && opc == OP_SAMPLE) begin
                    if (filling) begin
                        r_fill[ch] <= fill_cur + FILL_W'(1);
                    end else if (seq_open) begin
                        r_pos[ch] <= pos_cur + POS_W'(1);
                    end
                end
            end
        end
    end

    // Taps, biases and history hold no reset value.
    always_ff @(posedge i_clk) begin
        if (accept && ch_ok) begin
            unique case (opc)
                OP_LOAD_TAP: begin
                    if (32'(i_in.tap_index) < TAPS) begin
                        r_taps[ch][TAP_IDX_W'(i_in.tap_index)] <= i_in.value;
                    end
                end
                OP_LOAD_BIAS: begin
                    r_bias[ch] <= i_in.bias_value;
                end
                OP_SAMPLE: begin
                    if (filling) begin
                        r_hist[ch][fill_cur[HIST_IDX_W-1:0]] <= i_in.value;
                    end else if (seq_open) begin
                        r_hist[ch] <= hist_shifted;
                    end
                end
                OP_RESTART: begin
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && opc == OP_RESTART) |=> (r_fill[0] == '0 && r_pos[0] == '0))
        else $error("restart did not clear channel sequence state");

    a_push_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (32'(fill_cur) == TAPS - 1))
        else $error("result issued before the window was full");
`endif

endmodule

// ----- rtl/dcbr_fifo.sv -----
// ============================================================================
// dcbr_fifo - job queue between front end and back end
// Short first-in first-out queue that lets each side stall on its own.
// ============================================================================
module dcbr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dcbr_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output dcbr_pkg::t_job o_job,
    input  logic           i_pop
);
    import dcbr_pkg::*;

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (32'(r_count) == FIFO_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (32'(r_wr) == FIFO_DEPTH - 1) ? '0 : r_wr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (32'(r_rd) == FIFO_DEPTH - 1) ? '0 : r_rd + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("job popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= FIFO_DEPTH)
        else $error("queue count out of range");
`endif

endmodule

// ----- rtl/dcbr_back.sv -----
// ============================================================================
// dcbr_back - multiply, accumulate, bias, ReLU and clamp
// Three-stage pipeline: tap products, product sum, bias add with clamp into
// the output register.
// ============================================================================
module dcbr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  dcbr_pkg::t_job i_q_job,
    output logic           o_pop,
    dcbr_out_if.source     o_out
);
    import dcbr_pkg::*;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [BIAS_W-1:0] r_bias1;
    logic signed [BIAS_W-1:0] r_bias2;
    logic signed [PSUM_W-1:0] r_psum;
    t_meta                    r_meta1;
    t_meta                    r_meta2;
    t_meta                    r_meta3;
    logic [VAL_W-1:0]         r_val;

    logic                     adv;
    logic signed [PROD_W-1:0] prod [TAPS];
    logic signed [PSUM_W-1:0] psum;
    logic signed [ACC_W-1:0]  acc;
    logic [VAL_W-1:0]         clamped;

    // The whole pipeline moves together whenever the output register frees.
    assign adv   = !r_v3 || o_out.ready;
    assign o_pop = adv && i_q_valid;

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            prod[k] = i_q_job.window[k] * i_q_job.taps[k];
        end
    end

    always_comb begin
        psum = '0;
        for (int k = 0; k < TAPS; k++) begin
            psum = psum + PSUM_W'(r_prod[k]);
        end
    end

    assign acc = ACC_W'(r_psum) + ACC_W'(r_bias2);

    always_comb begin
        if (acc < 0) begin
            clamped = '0;
        end else if (acc > CLAMP_MAX) begin
            clamped = VAL_W'(CLAMP_MAX);
        end else begin
            clamped = acc[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < TAPS; k++) begin
                r_prod[k] <= prod[k];
            end
            r_bias1 <= i_q_job.bias;
            r_meta1 <= i_q_job.meta;
            r_psum  <= psum;
            r_bias2 <= r_bias1;
            r_meta2 <= r_meta1;
            r_val   <= clamped;
            r_meta3 <= r_meta2;
        end
    end

    assign o_out.valid        = r_v3;
    assign o_out.out_channel  = r_meta3.channel;
    assign o_out.position     = r_meta3.position;
    assign o_out.output_value = r_val;
    assign o_out.is_last      = r_meta3.is_last;

`ifndef SYNTHESIS
    a_pop_only_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_q_valid && adv))
        else $error("queue popped while the pipeline was held");
`endif

endmodule

// ----- rtl/depthwise_conv1d_bias_relu_int8_top.sv -----
// Path: a result travels from the edge that accepts its sample through the queue write,
// product stage, sum stage and output register, and a held output channel stalls it.
// Throughput: one item per cycle while the job queue is not full, set by the front end
// and the fully pipelined multiply/accumulate path; a two-entry job queue absorbs stalls.
// Reset: clears fill levels, positions, queue and pipeline valid state and sets
// output_count to 512; taps, biases and sample history hold no reset value.
// ============================================================================
// depthwise_conv1d_bias_relu_int8_top - depthwise 5-tap int8 convolution
// Per-channel convolution over an interleaved sample stream with bias, ReLU
// and a clamp to 0..127.
// ============================================================================
module depthwise_conv1d_bias_relu_int8_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcbr_in_if.sink    i_in,
    dcbr_cfg_if.sink   i_cfg,
    dcbr_out_if.source o_out
);
    import dcbr_pkg::*;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_job push_job;
    t_job pop_job;

    dcbr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    dcbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (pop_job),
        .i_pop   (q_pop)
    );

    dcbr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (pop_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
